// ===== design/ic3_pkg.sv =====
// Shared types and constants for the 3x3 image convolution block.
// No dependencies; used by every module of the block by scoped names.
package ic3_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_W      = 16;
    localparam int ROW_BITS    = KERNEL_SIZE * COEF_W;
    localparam int VALUE_W     = 28;
    localparam int ROW_W       = 12;
    localparam int OUT_COL_W   = 10;
    localparam int HEIGHT_W    = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WIDTH_CFG_W = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam logic [ROW_BITS-1:0] KERNEL_TOP_RESET    = 48'h0000_0000_0000;
    localparam logic [ROW_BITS-1:0] KERNEL_MIDDLE_RESET = 48'h0000_0100_0000;
    localparam logic [ROW_BITS-1:0] KERNEL_BOTTOM_RESET = 48'h0000_0000_0000;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MIDDLE = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } cfg_index_t;

    typedef logic [KERNEL_SIZE-1:0][ROW_BITS-1:0] kernel_t;

endpackage

// ===== design/ic3_cfg.sv =====
// Configuration registers: kernel rows, image size with clamping.
// Depends on ic3_pkg.
module ic3_cfg #(
    parameter int MAX_WIDTH = 1024,
    localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ic3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ic3_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ic3_pkg::kernel_t                  kernel_o,
    output logic [WID_W-1:0]                  width_o,
    output logic [ic3_pkg::HEIGHT_W-1:0]      height_o,
    output logic                              restart_o
);

    localparam int WIDTH_INIT = (MAX_WIDTH < ic3_pkg::WIDTH_RESET) ? MAX_WIDTH
                                                                   : ic3_pkg::WIDTH_RESET;

    ic3_pkg::kernel_t                 kernel_reg, kernel_next;
    logic [WID_W-1:0]                 width_reg, width_next;
    logic [ic3_pkg::HEIGHT_W-1:0]     height_reg, height_next;
    logic                             wr;
    logic [ic3_pkg::WIDTH_CFG_W-1:0]  w_raw;
    logic [ic3_pkg::HEIGHT_W-1:0]     h_raw;

    assign cfg_ready = 1'b1;
    assign kernel_o  = kernel_reg;
    assign width_o   = width_reg;
    assign height_o  = height_reg;

    always_comb begin
        wr          = cfg_valid && cfg_ready;
        w_raw       = cfg_data[ic3_pkg::WIDTH_CFG_W-1:0];
        h_raw       = cfg_data[ic3_pkg::HEIGHT_W-1:0];
        kernel_next = kernel_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart_o   = 1'b0;
        if (wr) begin
            case (cfg_index)
                ic3_pkg::CFG_KERNEL_TOP: begin
                    kernel_next[0] = cfg_data;
                end
                ic3_pkg::CFG_KERNEL_MIDDLE: begin
                    kernel_next[1] = cfg_data;
                end
                ic3_pkg::CFG_KERNEL_BOTTOM: begin
                    kernel_next[2] = cfg_data;
                end
                ic3_pkg::CFG_IMAGE_WIDTH: begin
                    restart_o = 1'b1;
                    if (w_raw == '0) begin
                        width_next = WID_W'(1);
                    end else if (32'(w_raw) > MAX_WIDTH) begin
                        width_next = WID_W'(MAX_WIDTH);
                    end else begin
                        width_next = WID_W'(w_raw);
                    end
                end
                ic3_pkg::CFG_IMAGE_HEIGHT: begin
                    restart_o = 1'b1;
                    if (h_raw == '0) begin
                        height_next = ic3_pkg::HEIGHT_W'(1);
                    end else if (32'(h_raw) > ic3_pkg::MAX_HEIGHT) begin
                        height_next = ic3_pkg::HEIGHT_W'(ic3_pkg::MAX_HEIGHT);
                    end else begin
                        height_next = h_raw;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg[0] <= ic3_pkg::KERNEL_TOP_RESET;
            kernel_reg[1] <= ic3_pkg::KERNEL_MIDDLE_RESET;
            kernel_reg[2] <= ic3_pkg::KERNEL_BOTTOM_RESET;
            width_reg     <= WID_W'(WIDTH_INIT);
            height_reg    <= ic3_pkg::HEIGHT_W'(ic3_pkg::HEIGHT_RESET);
        end else begin
            kernel_reg    <= kernel_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

endmodule

// ===== design/ic3_front.sv =====
// Front end: accepts words, classifies pixel/flush, tracks stream position,
// runs the two line stores and the 3x3 window, and pushes jobs. Uses ic3_pkg.
module ic3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int WID_W  = $clog2(MAX_WIDTH + 1),
    localparam int PEND_W = $clog2(MAX_WIDTH + 2),
    localparam int PIX_ALL_W = ic3_pkg::TAPS * PIXEL_BITS,
    localparam int JOB_W  = 1 + ic3_pkg::ROW_W + ic3_pkg::OUT_COL_W + PIX_ALL_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [PIXEL_BITS-1:0]          s_pixel,
    input  logic [WID_W-1:0]               width_i,
    input  logic [ic3_pkg::HEIGHT_W-1:0]   height_i,
    input  logic                           restart_i,
    input  logic [ic3_pkg::QCNT_W-1:0]     q_level_i,
    output logic                           push_o,
    output logic [JOB_W-1:0]               job_o
);

    localparam int K = ic3_pkg::KERNEL_SIZE;

    logic [ic3_pkg::ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]          in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [PEND_W-1:0]         pend_reg, pend_next;
    logic                      flushing_reg, flushing_next;

    logic [ic3_pkg::ROW_W-1:0] cur_in_row, cur_out_row;
    logic [COL_W-1:0]          cur_in_col, cur_out_col;
    logic [PEND_W-1:0]         cur_pend;
    logic                      acc, proc, op_flush, done, restart_in, emit, last;
    logic [PIXEL_BITS-1:0]     pix_eff;
    logic [3:0]                mask;
    logic [COL_W+ic3_pkg::OUT_COL_W-1:0] col_ext;

    logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] older_rd_reg, newer_rd_reg, fwd_data_reg;
    logic                  fwd_hit_reg;

    logic                           s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [PIXEL_BITS-1:0]          s1_pix_reg;
    logic [COL_W-1:0]               s1_col_reg;
    logic [3:0]                     s1_mask_reg;
    logic [ic3_pkg::ROW_W-1:0]      s1_row_reg;
    logic [ic3_pkg::OUT_COL_W-1:0]  s1_ocol_reg;

    logic [PIXEL_BITS-1:0] win_reg [K][K];
    logic [PIXEL_BITS-1:0] win_next [K][K];
    logic [PIXEL_BITS-1:0] top_pix;
    logic [PIX_ALL_W-1:0]  pix_all;

    // mask bits: 0 top row, 1 bottom row, 2 left col, 3 right col
    always_comb begin
        s_ready     = (32'(q_level_i) + 32'(s1_valid_reg)) < ic3_pkg::QDEPTH;
        acc         = s_valid && s_ready;
        op_flush    = (s_op == ic3_pkg::OP_FLUSH);
        done        = (in_row_reg == '0) && (in_col_reg == '0) && (pend_reg != '0);
        proc        = acc && (!op_flush || flushing_reg || done);
        restart_in  = !op_flush && flushing_reg;
        cur_in_row  = restart_in ? '0 : in_row_reg;
        cur_in_col  = restart_in ? '0 : in_col_reg;
        cur_out_row = restart_in ? '0 : out_row_reg;
        cur_out_col = restart_in ? '0 : out_col_reg;
        cur_pend    = restart_in ? '0 : pend_reg;
        pix_eff     = op_flush ? '0 : s_pixel;
        emit        = 32'(cur_pend) > 32'(width_i);
        last        = (32'(cur_out_col) + 32'd1 >= 32'(width_i)) &&
                      (32'(cur_out_row) + 32'd1 >= 32'(height_i));
        mask[0]     = cur_out_row != '0;
        mask[1]     = 32'(cur_out_row) + 32'd1 < 32'(height_i);
        mask[2]     = cur_out_col != '0;
        mask[3]     = 32'(cur_out_col) + 32'd1 < 32'(width_i);
        col_ext     = {{ic3_pkg::OUT_COL_W{1'b0}}, cur_out_col};

        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        pend_next     = pend_reg;
        flushing_next = flushing_reg;
        if (restart_i) begin
            in_row_next   = '0;
            in_col_next   = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            pend_next     = '0;
            flushing_next = 1'b0;
        end else if (proc) begin
            flushing_next = op_flush;
            if (32'(cur_in_col) + 32'd1 >= 32'(width_i)) begin
                in_col_next = '0;
                if (32'(cur_in_row) + 32'd1 >= 32'(height_i)) begin
                    in_row_next = '0;
                end else begin
                    in_row_next = cur_in_row + 1'b1;
                end
            end else begin
                in_col_next = cur_in_col + 1'b1;
                in_row_next = cur_in_row;
            end
            out_row_next = cur_out_row;
            out_col_next = cur_out_col;
            pend_next    = cur_pend;
            if (!emit) begin
                pend_next = cur_pend + 1'b1;
            end else begin
                if (32'(cur_out_col) + 32'd1 >= 32'(width_i)) begin
                    out_col_next = '0;
                    if (32'(cur_out_row) + 32'd1 >= 32'(height_i)) begin
                        out_row_next = '0;
                    end else begin
                        out_row_next = cur_out_row + 1'b1;
                    end
                end else begin
                    out_col_next = cur_out_col + 1'b1;
                end
                if (last && op_flush) begin
                    in_row_next   = '0;
                    in_col_next   = '0;
                    out_row_next  = '0;
                    out_col_next  = '0;
                    pend_next     = '0;
                    flushing_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            pend_reg     <= '0;
            flushing_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            pend_reg     <= pend_next;
            flushing_reg <= flushing_next;
            s1_valid_reg <= proc;
        end
    end

    // line stores; the older store is written from the newer read data in the following cycle
    always_ff @(posedge aclk) begin
        if (proc) begin
            newer_rd_reg          <= newer_mem[cur_in_col];
            newer_mem[cur_in_col] <= pix_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            older_rd_reg <= older_mem[cur_in_col];
        end
        if (s1_valid_reg) begin
            older_mem[s1_col_reg] <= newer_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            fwd_hit_reg  <= s1_valid_reg && (s1_col_reg == cur_in_col);
            fwd_data_reg <= newer_rd_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_pix_reg   <= pix_eff;
            s1_col_reg   <= cur_in_col;
            s1_mask_reg  <= mask;
            s1_row_reg   <= cur_out_row;
            s1_ocol_reg  <= col_ext[ic3_pkg::OUT_COL_W-1:0];
        end
    end

    always_comb begin
        top_pix = fwd_hit_reg ? fwd_data_reg : older_rd_reg;
        for (int r = 0; r < K; r++) begin
            for (int k = 0; k < K - 1; k++) begin
                win_next[r][k] = win_reg[r][k+1];
            end
        end
        win_next[0][K-1] = top_pix;
        win_next[1][K-1] = newer_rd_reg;
        win_next[2][K-1] = s1_pix_reg;
        for (int r = 0; r < K; r++) begin
            for (int k = 0; k < K; k++) begin
                if ((r == 0 && !s1_mask_reg[0]) || (r == K - 1 && !s1_mask_reg[1]) ||
                    (k == 0 && !s1_mask_reg[2]) || (k == K - 1 && !s1_mask_reg[3])) begin
                    pix_all[(r*K+k)*PIXEL_BITS +: PIXEL_BITS] = '0;
                end else begin
                    pix_all[(r*K+k)*PIXEL_BITS +: PIXEL_BITS] = win_next[r][k];
                end
            end
        end
        push_o = s1_valid_reg && s1_emit_reg;
        job_o  = {s1_last_reg, s1_row_reg, s1_ocol_reg, pix_all};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < K; r++) begin
                for (int k = 0; k < K; k++) begin
                    win_reg[r][k] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== design/ic3_queue.sv =====
// Short job queue between the front end and the multiply-accumulate back end.
// Depends on ic3_pkg for depth and pointer widths.
module ic3_queue #(
    parameter int DATA_W = 95
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_i,
    input  logic [DATA_W-1:0]           data_i,
    input  logic                        pop_i,
    output logic [DATA_W-1:0]           data_o,
    output logic                        empty_o,
    output logic [ic3_pkg::QCNT_W-1:0]  level_o
);

    logic [DATA_W-1:0]            slot_reg [ic3_pkg::QDEPTH];
    logic [ic3_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [ic3_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_pop;

    always_comb begin
        empty_o    = (count_reg == '0);
        do_pop     = pop_i && !empty_o;
        data_o     = slot_reg[rd_ptr_reg];
        level_o    = count_reg;
        count_next = count_reg;
        if (push_i && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_i && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            slot_reg[wr_ptr_reg] <= data_i;
        end
    end

endmodule

// ===== design/ic3_back.sv =====
// Back end: nine multiplies, row sums, final sum into the output register.
// Depends on ic3_pkg; takes jobs from ic3_queue.
module ic3_back #(
    parameter int PIXEL_BITS = 8,
    localparam int PIX_ALL_W = ic3_pkg::TAPS * PIXEL_BITS,
    localparam int JOB_W = 1 + ic3_pkg::ROW_W + ic3_pkg::OUT_COL_W + PIX_ALL_W
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ic3_pkg::kernel_t                      kernel_i,
    input  logic                                  q_empty_i,
    input  logic [JOB_W-1:0]                      job_i,
    output logic                                  pop_o,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ic3_pkg::VALUE_W-1:0]    m_filtered_value,
    output logic [ic3_pkg::ROW_W-1:0]             m_out_row,
    output logic [ic3_pkg::OUT_COL_W-1:0]         m_out_col,
    output logic                                  m_frame_end
);

    localparam int K      = ic3_pkg::KERNEL_SIZE;
    localparam int PROD_W = PIXEL_BITS + 1 + ic3_pkg::COEF_W;
    localparam int RSUM_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    logic adv;
    logic b1_valid_reg, b2_valid_reg, m_valid_reg;

    logic signed [PROD_W-1:0]          prod_reg [ic3_pkg::TAPS];
    logic [ic3_pkg::ROW_W-1:0]         b1_row_reg, b2_row_reg, m_row_reg;
    logic [ic3_pkg::OUT_COL_W-1:0]     b1_col_reg, b2_col_reg, m_col_reg;
    logic                              b1_last_reg, b2_last_reg, m_last_reg;
    logic signed [RSUM_W-1:0]          rsum_reg [K];
    logic signed [SUM_W-1:0]           sum;
    logic signed [ic3_pkg::VALUE_W-1:0] m_value_reg;

    always_comb begin
        adv   = !m_valid_reg || m_ready;
        pop_o = adv && !q_empty_i;
        sum   = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= pop_o;
            b2_valid_reg <= b1_valid_reg;
            m_valid_reg  <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < K; r++) begin
                for (int k = 0; k < K; k++) begin
                    prod_reg[r*K+k] <=
                        $signed({1'b0, job_i[(r*K+k)*PIXEL_BITS +: PIXEL_BITS]}) *
                        $signed(kernel_i[r][k*ic3_pkg::COEF_W +: ic3_pkg::COEF_W]);
                end
            end
            b1_last_reg <= job_i[JOB_W-1];
            b1_row_reg  <= job_i[JOB_W-2 -: ic3_pkg::ROW_W];
            b1_col_reg  <= job_i[PIX_ALL_W +: ic3_pkg::OUT_COL_W];

            for (int r = 0; r < K; r++) begin
                rsum_reg[r] <= RSUM_W'(prod_reg[r*K]) + RSUM_W'(prod_reg[r*K+1]) +
                               RSUM_W'(prod_reg[r*K+2]);
            end
            b2_last_reg <= b1_last_reg;
            b2_row_reg  <= b1_row_reg;
            b2_col_reg  <= b1_col_reg;

            m_value_reg <= sum[ic3_pkg::VALUE_W-1:0];
            m_last_reg  <= b2_last_reg;
            m_row_reg   <= b2_row_reg;
            m_col_reg   <= b2_col_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_value_reg;
    assign m_out_row        = m_row_reg;
    assign m_out_col        = m_col_reg;
    assign m_frame_end      = m_last_reg;

endmodule

// ===== design/image_convolution_3x3.sv =====
// 3x3 image convolution with zero padding: top level.
// Depends on ic3_pkg, ic3_cfg, ic3_front, ic3_queue, ic3_back.
//
// Takes one pixel word per clock in raster order while s_ready is high, and
// returns the filtered frame, one word per clock while m_ready is high, at
// full precision (Q with 8 fraction bits). The result for pixel k leaves
// with input word k+W+1; after the last pixel of a frame, flush words push
// out the remaining outputs. A word passes the front end (line store read,
// window update) and the multiply-accumulate back end, behind a four-entry
// job queue; s_ready drops only when that queue, with the word in the front
// end, fills under output back-pressure. The line stores are block memories
// of MAX_WIDTH entries each with one read and one write per cycle, need no
// clearing after reset, and rows above the frame are masked to zero.
// Changing image_width or image_height restarts the stream position.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ic3_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ic3_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [PIXEL_BITS-1:0]                s_pixel,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ic3_pkg::VALUE_W-1:0]   m_filtered_value,
    output logic [ic3_pkg::ROW_W-1:0]            m_out_row,
    output logic [ic3_pkg::OUT_COL_W-1:0]        m_out_col,
    output logic                                 m_frame_end
);

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int JOB_W = 1 + ic3_pkg::ROW_W + ic3_pkg::OUT_COL_W +
                           ic3_pkg::TAPS * PIXEL_BITS;

    ic3_pkg::kernel_t               kernel;
    logic [WID_W-1:0]               width;
    logic [ic3_pkg::HEIGHT_W-1:0]   height;
    logic                           restart;
    logic                           push, pop, q_empty;
    logic [JOB_W-1:0]               job_in, job_out;
    logic [ic3_pkg::QCNT_W-1:0]     q_level;

    ic3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kernel_o  (kernel),
        .width_o   (width),
        .height_o  (height),
        .restart_o (restart)
    );

    ic3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_pixel   (s_pixel),
        .width_i   (width),
        .height_i  (height),
        .restart_i (restart),
        .q_level_i (q_level),
        .push_o    (push),
        .job_o     (job_in)
    );

    ic3_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .data_i  (job_in),
        .pop_i   (pop),
        .data_o  (job_out),
        .empty_o (q_empty),
        .level_o (q_level)
    );

    ic3_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .kernel_i         (kernel),
        .q_empty_i        (q_empty),
        .job_i            (job_out),
        .pop_o            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_frame_end      (m_frame_end)
    );

endmodule
